>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/slyf_pkg.sv
// Package for the serial line / YMODEM framer: codes, constants and shared types.
`default_nettype none

package slyf_pkg;

    localparam int BUF_SIZE_DEF = 2048;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 12;
    localparam int SIDX_W  = 11;

    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;

    localparam logic [COUNT_W-1:0] SOH_PACKET_LEN = COUNT_W'(128 + 5);
    localparam logic [COUNT_W-1:0] STX_PACKET_LEN = COUNT_W'(1024 + 5);
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic MODE_LINE   = 1'b0;
    localparam logic MODE_YMODEM = 1'b1;

    // Framer state whose width does not follow the buffer size.
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [BYTE_W-1:0]  previous_byte;
        logic               previous_valid;
        logic [BYTE_W-1:0]  first_byte;
    } slyf_state_t;

    typedef struct packed {
        logic              store_valid;
        logic [SIDX_W-1:0] store_index;
        logic [BYTE_W-1:0] store_byte;
        logic              line_done;
        logic              packet_done;
        logic              frame_restarted;
    } slyf_result_t;

endpackage

`default_nettype wire

>>> rtl/core/slyf_step.sv
// Per-word framing logic: next state and result for one request.
`default_nettype none

module slyf_step #(
    parameter int BUF_SIZE = slyf_pkg::BUF_SIZE_DEF,
    parameter int IDX_W    = $clog2(BUF_SIZE)
) (
    input  wire logic                     framing_mode,
    input  wire logic                     req_type,
    input  wire logic [7:0]               rx_byte,
    input  wire logic [IDX_W-1:0]         cur_index,
    input  wire slyf_pkg::slyf_state_t    cur_state,
    output logic      [IDX_W-1:0]         nxt_index,
    output slyf_pkg::slyf_state_t         nxt_state,
    output slyf_pkg::slyf_result_t        result
);
    import slyf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(BUF_SIZE - 1);

    logic [IDX_W-1:0]   inc_index;
    logic               wrap;
    logic [BYTE_W-1:0]  first_now;
    logic [COUNT_W-1:0] count_inc;
    logic               do_advance;
    logic               do_clear;

    assign inc_index = cur_index + IDX_W'(1);
    assign wrap      = (cur_index == LAST_INDEX);
    assign first_now = (cur_index == '0) ? rx_byte : cur_state.first_byte;
    assign count_inc = (cur_state.byte_count == COUNT_MAX) ? cur_state.byte_count
                                                           : cur_state.byte_count + COUNT_W'(1);

    always_comb begin
        nxt_index  = cur_index;
        nxt_state  = cur_state;
        result     = '0;
        do_advance = 1'b0;
        do_clear   = 1'b0;

        if (req_type == REQ_RESTART) begin
            do_clear               = 1'b1;
            result.frame_restarted = 1'b1;
        end else begin
            nxt_state.first_byte = first_now;
            nxt_state.byte_count = count_inc;
            result.store_valid   = 1'b1;
            result.store_index   = cur_index[SIDX_W-1:0];
            result.store_byte    = rx_byte;

            unique case (framing_mode)
                MODE_LINE: begin
                    if (rx_byte == CH_LF) begin
                        // LF without a stored CR stays put and gets overwritten
                        if (cur_state.previous_valid && cur_state.previous_byte == CH_CR) begin
                            result.line_done       = 1'b1;
                            result.frame_restarted = 1'b1;
                            do_clear               = 1'b1;
                        end
                    end else begin
                        do_advance = 1'b1;
                        if (wrap) begin
                            do_clear               = 1'b1;
                            result.frame_restarted = 1'b1;
                        end
                    end
                    if (first_now == CH_NUL) begin
                        do_clear               = 1'b1;
                        result.frame_restarted = 1'b1;
                    end
                end
                MODE_YMODEM: begin
                    priority case (first_now)
                        CH_SOH: begin
                            do_advance         = (count_inc <= SOH_PACKET_LEN);
                            result.packet_done = (count_inc == SOH_PACKET_LEN);
                        end
                        CH_STX: begin
                            do_advance         = (count_inc <= STX_PACKET_LEN);
                            result.packet_done = (count_inc == STX_PACKET_LEN);
                        end
                        CH_EOT: begin
                            do_advance = 1'b1;
                        end
                        default: begin
                            do_clear               = 1'b1;
                            result.frame_restarted = 1'b1;
                        end
                    endcase
                end
                default: begin
                    do_clear = 1'b1;
                end
            endcase
        end

        // advance first, a clear from the same word overrides it
        if (do_advance) begin
            if (wrap) begin
                nxt_index                = '0;
                nxt_state.previous_valid = 1'b0;
            end else begin
                nxt_index                = inc_index;
                nxt_state.previous_byte  = rx_byte;
                nxt_state.previous_valid = 1'b1;
            end
        end
        if (do_clear) begin
            nxt_index                = '0;
            nxt_state.byte_count     = '0;
            nxt_state.previous_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/serial_line_and_ymodem_framer_top.sv
// Top level of the serial line / YMODEM receive framer with a two-deep result buffer.
//
//  channel   direction  handshake               payload
//  s_        in         s_tvalid / s_tready     s_tuser = req_type, s_tdata = rx_byte
//  m_        out        m_tvalid / m_tready     m_tuser = store_valid, m_tdata = write report
//  cfg_      in         cfg_valid / cfg_ready   cfg_data = framing_mode
//
//  One word per cycle while s_tready is high: framer state updates at the accepting
//  edge and the result is registered in the output register or, on a stall, the skid entry.
//  The output register plus one skid entry keep s_tready high while one result waits.
//  aresetn is synchronous, active low; it clears mode, index, count and history.
//  s_tready drops only when both result entries are full.
`default_nettype none

module serial_line_and_ymodem_framer_top #(
    parameter int BUF_SIZE = slyf_pkg::BUF_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,     // [0] framing_mode

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  wire logic        s_tuser,      // [0] req_type

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,      // [10:0] store_index, [18:11] store_byte,
                                           // [19] line_done, [20] packet_done,
                                           // [21] frame_restarted, [23:22] zero
    output logic             m_tuser       // [0] store_valid
);
    import slyf_pkg::*;

    localparam int IDX_W = $clog2(BUF_SIZE);

    logic               mode_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [IDX_W-1:0]   index_next;
    slyf_state_t        state_reg;
    slyf_state_t        state_next;
    slyf_result_t       step_result;

    logic               out_valid_reg, out_valid_next;
    slyf_result_t       out_reg, out_next;
    logic               skid_valid_reg, skid_valid_next;
    slyf_result_t       skid_reg, skid_next;

    logic               accept;
    logic               drain;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign drain     = !out_valid_reg || m_tready;

    slyf_step #(
        .BUF_SIZE (BUF_SIZE),
        .IDX_W    (IDX_W)
    ) u_step (
        .framing_mode (mode_reg),
        .req_type     (s_tuser),
        .rx_byte      (s_tdata),
        .cur_index    (index_reg),
        .cur_state    (state_reg),
        .nxt_index    (index_next),
        .nxt_state    (state_next),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_LINE;
            index_reg <= '0;
            state_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (accept) begin
                index_reg <= index_next;
                state_reg <= state_next;
            end
        end
    end

    // Output register with one skid entry behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (drain) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                out_next       = step_result;
            end
        end else if (accept) begin
            // hold the stalled word, park the new one
            skid_valid_next = 1'b1;
            skid_next       = step_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.store_valid;
    assign m_tdata  = {2'b00, out_reg.frame_restarted, out_reg.packet_done,
                       out_reg.line_done, out_reg.store_byte, out_reg.store_index};

`include "assert_macros.svh"

    `ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_restart_clears, accept && s_tuser == REQ_RESTART,
                 index_reg == '0 && state_reg.byte_count == '0 && !state_reg.previous_valid)
    `ASSERT_NOW(a_line_done_restarts, m_tvalid && out_reg.line_done,
                out_reg.frame_restarted && out_reg.store_valid)
    `ASSERT_NOW(a_history_not_at_zero, state_reg.previous_valid, index_reg != '0)

endmodule

`default_nettype wire

>>> bench/tb_serial_line_and_ymodem_framer_top.sv
// Self-checking bench for the serial line / YMODEM receive framer top level.
`default_nettype none

module tb_serial_line_and_ymodem_framer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slyf_pkg::*;

    localparam int RX_BUF_LEN = BUF_SIZE_DEF;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = MODE_LINE;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = REQ_BYTE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    serial_line_and_ymodem_framer_top #(.BUF_SIZE(RX_BUF_LEN)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Framer model state
    logic               mode_reg;
    int                 wr_idx;
    logic [COUNT_W-1:0] rx_count;
    logic [BYTE_W-1:0]  last_byte;
    logic               last_ok;
    logic [BYTE_W-1:0]  head_byte;

    slyf_result_t store_reports_q[$];
    int mismatch_count = 0;
    int words_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    function automatic void clear_frame_model();
        wr_idx   = 0;
        rx_count = '0;
        last_ok  = 1'b0;
    endfunction

    // Advance past byte b; report a wrap to position 0.
    function automatic bit bump_index(input logic [7:0] b);
        wr_idx++;
        if (wr_idx >= RX_BUF_LEN) begin
            wr_idx  = 0;
            last_ok = 1'b0;
            return 1'b1;
        end
        last_byte = b;
        last_ok   = 1'b1;
        return 1'b0;
    endfunction

    function automatic slyf_result_t frame_word(input logic req, input logic [7:0] b);
        slyf_result_t r;
        r = '0;
        if (req == REQ_RESTART) begin
            clear_frame_model();
            r.frame_restarted = 1'b1;
            return r;
        end
        r.store_valid = 1'b1;
        r.store_index = SIDX_W'(wr_idx);
        r.store_byte  = b;
        if (wr_idx == 0)
            head_byte = b;
        if (rx_count != COUNT_MAX)
            rx_count++;
        if (mode_reg == MODE_LINE) begin
            if (b == CH_LF) begin
                if (last_ok && last_byte == CH_CR) begin
                    r.line_done       = 1'b1;
                    r.frame_restarted = 1'b1;
                    clear_frame_model();
                end
            end else if (bump_index(b)) begin
                rx_count          = '0;
                r.frame_restarted = 1'b1;
            end
            if (head_byte == CH_NUL) begin
                clear_frame_model();
                r.frame_restarted = 1'b1;
            end
        end else begin
            case (head_byte)
                CH_SOH: begin
                    if (rx_count <= SOH_PACKET_LEN) begin
                        r.packet_done = (rx_count == SOH_PACKET_LEN);
                        void'(bump_index(b));
                    end
                end
                CH_STX: begin
                    if (rx_count <= STX_PACKET_LEN) begin
                        r.packet_done = (rx_count == STX_PACKET_LEN);
                        void'(bump_index(b));
                    end
                end
                CH_EOT: begin
                    void'(bump_index(b));
                end
                default: begin
                    clear_frame_model();
                    r.frame_restarted = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // Predict on accepted input words, then check accepted result words.
    always @(posedge aclk) begin : scoreboard
        slyf_result_t got, want;
        if (!aresetn) begin
            mode_reg  = MODE_LINE;
            last_byte = '0;
            head_byte = '0;
            clear_frame_model();
        end else begin
            if (cfg_valid && cfg_ready)
                mode_reg = cfg_data;
            if (s_tvalid && s_tready)
                store_reports_q.push_back(frame_word(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got.store_valid     = m_tuser;
                got.store_index     = m_tdata[10:0];
                got.store_byte      = m_tdata[18:11];
                got.line_done       = m_tdata[19];
                got.packet_done     = m_tdata[20];
                got.frame_restarted = m_tdata[21];
                if (store_reports_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: tuser=%0d tdata=%h",
                                 m_tuser, m_tdata);
                end else begin
                    want = store_reports_q.pop_front();
                    if (got.store_valid !== want.store_valid ||
                        got.store_index !== want.store_index ||
                        got.store_byte !== want.store_byte ||
                        got.line_done !== want.line_done ||
                        got.packet_done !== want.packet_done ||
                        got.frame_restarted !== want.frame_restarted) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: exp v=%0d idx=%0d b=%h ln=%0d pk=%0d rs=%0d",
                                     want.store_valid, want.store_index, want.store_byte,
                                     want.line_done, want.packet_done, want.frame_restarted);
                            $display("          got v=%0d idx=%0d b=%h ln=%0d pk=%0d rs=%0d",
                                     got.store_valid, got.store_index, got.store_byte,
                                     got.line_done, got.packet_done, got.frame_restarted);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_word(input logic req, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(REQ_BYTE, b);
    endtask

    // rx_byte is don't-care on a restart, so fill it at random.
    task automatic send_restart();
        send_word(REQ_RESTART, 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] lead_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_NUL);
        return b;
    endfunction

    // Hold off until every predicted word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (store_reports_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Runs in the reset mode, so no register write first.
    task automatic test_line_directed();
        send_byte(CH_NUL);          // NUL at position 0 restarts
        send_byte(CH_LF);           // LF at index 0, no look-back
        send_byte(8'h41);
        send_byte(CH_CR);
        send_byte(CH_LF);           // line done
        send_byte(CH_LF);           // CR still in buffer but index is 0
        send_byte(8'h42);
        send_byte(8'h43);
        send_byte(CH_LF);           // stray LF, overwritten next
        send_byte(8'h44);
        send_restart();
        send_byte(8'hFF);
        send_byte(CH_NUL);
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_ymodem_directed();
        set_mode(MODE_YMODEM);
        send_restart();
        send_byte(8'h55);           // unknown first byte
        send_byte(CH_NUL);
        send_byte(CH_EOT);
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_byte(CH_NUL);
        send_restart();
        send_byte(CH_SOH);
        send_byte(8'h80);
        send_restart();
        send_byte(CH_STX);
        send_byte(8'h7F);
        send_restart();
        send_restart();
    endtask

    task automatic test_soh_packet();
        send_restart();
        send_byte(CH_SOH);
        repeat (int'(SOH_PACKET_LEN) - 1 + 3) send_byte(8'($urandom_range(255)));
        send_restart();
    endtask

    task automatic test_random_lines(input int n);
        int stop_at, kind, len;
        set_mode(MODE_LINE);
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                len = $urandom_range(40);
                if (len > 0) send_byte(lead_byte());
                for (int i = 1; i < len; i++) send_byte(text_byte());
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else if (kind < 80) begin
                send_byte(8'($urandom_range(255)));
            end else if (kind < 90) begin
                send_byte(CH_CR);
                send_byte(8'($urandom_range(255)));
                send_byte(CH_LF);
            end else begin
                send_restart();
            end
        end
    endtask

    task automatic test_random_frames(input int n);
        int stop_at, kind, len;
        set_mode(MODE_YMODEM);
        stop_at = words_sent + n;
        send_restart();
        while (words_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                send_byte(CH_SOH);
                len = int'(SOH_PACKET_LEN) - 1 + $urandom_range(3);
                repeat (len) send_byte(8'($urandom_range(255)));
                send_restart();
            end else if (kind < 60) begin
                send_byte(CH_EOT);
                repeat ($urandom_range(30)) send_byte(8'($urandom_range(255)));
                send_restart();
            end else if (kind < 70) begin
                // SOH or STX packet of random length, ended by a restart
                send_byte($urandom_range(1) ? CH_SOH : CH_STX);
                repeat ($urandom_range(1, 140)) send_byte(8'($urandom_range(255)));
                send_restart();
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else if (kind < 90) begin
                send_restart();
            end else begin
                send_byte(8'($urandom_range(255)));
                send_restart();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 9;
        recv_stall_pct = 52;
        test_line_directed();
        test_ymodem_directed();
        test_soh_packet();

        for (int phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin send_idle_pct = 9;  recv_stall_pct = 52; end
                1: begin send_idle_pct = 52; recv_stall_pct = 9;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            test_random_lines(200);
            test_random_frames(200);
        end

        drain();
        if (mismatch_count == 0)
            $display("serial_line_and_ymodem_framer_top test passed");
        else
            $display("serial_line_and_ymodem_framer_top test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("serial_line_and_ymodem_framer_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/slyf_pkg.sv
rtl/core/slyf_step.sv
rtl/core/serial_line_and_ymodem_framer_top.sv
bench/tb_serial_line_and_ymodem_framer_top.sv
